// ===== src/smfc_pkg.sv =====
package smfc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNELS      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_KERNEL_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIDE_ROW    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_STRIDE_COL    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_NUM_FILTERS   = 3'd7;

   localparam logic [1:0] REQ_LOAD_IMAGE  = 2'd0;
   localparam logic [1:0] REQ_LOAD_KERNEL = 2'd1;
   localparam logic [1:0] REQ_COMPUTE     = 2'd2;

   localparam int MAX_STRIDE = 8;
   localparam int SUM_W      = 40;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [13:0]        store_address;
      logic signed [15:0] sample_value;
      logic [5:0]         out_row;
      logic [5:0]         out_col;
      logic [2:0]         filter_index;
   } smfc_req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] conv_sum;
      logic                    request_bad;
   } smfc_rsp_type;

   typedef enum logic [1:0] {
      OP_LOAD_IMAGE,
      OP_LOAD_KERNEL,
      OP_COMPUTE,
      OP_BAD
   } smfc_op_type;

   typedef struct packed {
      smfc_op_type        op;
      logic [13:0]        addr;
      logic signed [15:0] sample;
      logic [5:0]         out_row;
      logic [5:0]         out_col;
      logic [2:0]         filt;
   } smfc_cmd_type;

   // clamped configuration
   typedef struct packed {
      logic [6:0] ih;
      logic [6:0] iw;
      logic [2:0] ch;
      logic [3:0] kh;
      logic [3:0] kw;
      logic [3:0] sr;
      logic [3:0] sc;
      logic [3:0] nf;
   } smfc_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP1,
      ST_SETUP2,
      ST_SETUP3,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } smfc_state_type;

endpackage

// ===== src/smfc_front.sv =====
module smfc_front #(
   parameter int MAX_IMAGE_SIDE  = 64,
   parameter int MAX_CHANNELS    = 4,
   parameter int MAX_KERNEL_SIDE = 8,
   parameter int MAX_FILTERS     = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [smfc_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [smfc_pkg::CSR_DATA_W-1:0]          csr_data,
   input  logic                                     req_valid,
   input  smfc_pkg::smfc_req_type                   req_payload,
   input  logic                                     q_full,
   output logic                                     q_push,
   output smfc_pkg::smfc_cmd_type                   q_cmd,
   output smfc_pkg::smfc_cfg_type                   cfg
);
   import smfc_pkg::*;

   localparam int IMG_DEPTH = MAX_IMAGE_SIDE * MAX_IMAGE_SIDE * MAX_CHANNELS;
   localparam int KER_DEPTH = MAX_FILTERS * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE * MAX_CHANNELS;

   logic [6:0] ih_ff, iw_ff;
   logic [2:0] ch_ff;
   logic [3:0] kh_ff, kw_ff, sr_ff, sc_ff, nf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ih_ff <= 7'd64;
         iw_ff <= 7'd64;
         ch_ff <= 3'd1;
         kh_ff <= 4'd3;
         kw_ff <= 4'd3;
         sr_ff <= 4'd1;
         sc_ff <= 4'd1;
         nf_ff <= 4'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_IMAGE_HEIGHT:  ih_ff <= csr_data;
            REG_IMAGE_WIDTH:   iw_ff <= csr_data;
            REG_CHANNELS:      ch_ff <= csr_data[2:0];
            REG_KERNEL_HEIGHT: kh_ff <= csr_data[3:0];
            REG_KERNEL_WIDTH:  kw_ff <= csr_data[3:0];
            REG_STRIDE_ROW:    sr_ff <= csr_data[3:0];
            REG_STRIDE_COL:    sc_ff <= csr_data[3:0];
            REG_NUM_FILTERS:   nf_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // zero reads as one, anything above the maximum as the maximum
   always_comb begin
      cfg.ih = (ih_ff == '0) ? 7'd1 : (32'(ih_ff) > MAX_IMAGE_SIDE) ? 7'(MAX_IMAGE_SIDE) : ih_ff;
      cfg.iw = (iw_ff == '0) ? 7'd1 : (32'(iw_ff) > MAX_IMAGE_SIDE) ? 7'(MAX_IMAGE_SIDE) : iw_ff;
      cfg.ch = (ch_ff == '0) ? 3'd1 : (32'(ch_ff) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : ch_ff;
      cfg.kh = (kh_ff == '0) ? 4'd1 :
               (32'(kh_ff) > MAX_KERNEL_SIDE) ? 4'(MAX_KERNEL_SIDE) : kh_ff;
      cfg.kw = (kw_ff == '0) ? 4'd1 :
               (32'(kw_ff) > MAX_KERNEL_SIDE) ? 4'(MAX_KERNEL_SIDE) : kw_ff;
      cfg.sr = (sr_ff == '0) ? 4'd1 : (32'(sr_ff) > MAX_STRIDE) ? 4'(MAX_STRIDE) : sr_ff;
      cfg.sc = (sc_ff == '0) ? 4'd1 : (32'(sc_ff) > MAX_STRIDE) ? 4'(MAX_STRIDE) : sc_ff;
      cfg.nf = (nf_ff == '0) ? 4'd1 : (32'(nf_ff) > MAX_FILTERS) ? 4'(MAX_FILTERS) : nf_ff;
   end

   logic [9:0] row_start, col_start;
   logic       bad;
   logic       keep;

   // out_row < 1 + (ih-1)/sr holds exactly when out_row*sr < ih
   assign row_start = 10'(req_payload.out_row) * 10'(cfg.sr);
   assign col_start = 10'(req_payload.out_col) * 10'(cfg.sc);
   assign bad = (row_start >= 10'(cfg.ih)) || (col_start >= 10'(cfg.iw)) ||
                ({1'b0, req_payload.filter_index} >= cfg.nf);

   always_comb begin
      q_cmd.addr    = req_payload.store_address;
      q_cmd.sample  = req_payload.sample_value;
      q_cmd.out_row = req_payload.out_row;
      q_cmd.out_col = req_payload.out_col;
      q_cmd.filt    = req_payload.filter_index;
      q_cmd.op      = OP_BAD;
      keep          = 1'b0;
      priority case (req_payload.req_type)
         REQ_LOAD_IMAGE: begin
            q_cmd.op = OP_LOAD_IMAGE;
            keep     = 32'(req_payload.store_address) < IMG_DEPTH;
         end
         REQ_LOAD_KERNEL: begin
            q_cmd.op = OP_LOAD_KERNEL;
            keep     = 32'(req_payload.store_address) < KER_DEPTH;
         end
         REQ_COMPUTE: begin
            q_cmd.op = bad ? OP_BAD : OP_COMPUTE;
            keep     = 1'b1;
         end
         default: ;
      endcase
   end

   assign q_push = req_valid && !q_full && keep;

endmodule

// ===== src/smfc_queue.sv =====
module smfc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  smfc_pkg::smfc_cmd_type push_cmd,
   output logic                   full,
   output logic                   pop_valid,
   input  logic                   pop,
   output smfc_pkg::smfc_cmd_type pop_cmd
);
   import smfc_pkg::*;

   localparam int DEPTH = 4;

   smfc_cmd_type entry_ff [DEPTH];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;

   assign full      = (count_ff == 3'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + 3'(push) - 3'(pop);
      end
   end

endmodule

// ===== src/smfc_back.sv =====
module smfc_back #(
   parameter int MAX_IMAGE_SIDE  = 64,
   parameter int MAX_CHANNELS    = 4,
   parameter int MAX_KERNEL_SIDE = 8,
   parameter int MAX_FILTERS     = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  smfc_pkg::smfc_cfg_type cfg,
   input  logic                   q_valid,
   input  smfc_pkg::smfc_cmd_type q_cmd,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output smfc_pkg::smfc_rsp_type rsp_payload
);
   import smfc_pkg::*;

   localparam int IMG_DEPTH = MAX_IMAGE_SIDE * MAX_IMAGE_SIDE * MAX_CHANNELS;
   localparam int KER_DEPTH = MAX_FILTERS * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE * MAX_CHANNELS;
   localparam int IMG_AW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
   localparam int KER_AW = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
   localparam int ACC_W = 33 + $clog2(MAX_KERNEL_SIDE * MAX_KERNEL_SIDE * MAX_CHANNELS + 1);
   localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SUM_MIN = ACC_W'(-(64'sd1 <<< (SUM_W - 1)));

   logic signed [15:0] img_mem [IMG_DEPTH];
   logic signed [15:0] ker_mem [KER_DEPTH];

   smfc_state_type state_ff, state_in;

   smfc_cmd_type cmd_ff, cmd_in;
   logic [9:0]        r0_ff, r0_in, c0_ff, c0_in;
   logic [6:0]        kf_ff, kf_in, kwch_ff, kwch_in;
   logic [IMG_AW-1:0] rs_ff, rs_in, ia_ff, ia_in, ia_row_ff, ia_row_in;
   logic [KER_AW-1:0] ka_ff, ka_in, ka_row_ff, ka_row_in;
   logic [3:0]        nrow_ff, nrow_in, ncol_ff, ncol_in;
   logic [3:0]        kr_ff, kr_in, kc_ff, kc_in;
   logic [2:0]        c_ff, c_in;
   logic              issue;

   logic              rd_v_ff, prod_v_ff;
   logic signed [15:0] img_q_ff, ker_q_ff;
   logic signed [31:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic              acc_clear;

   logic              out_load;
   logic              rsp_valid_ff;
   smfc_rsp_type      rsp_ff, rsp_in;

   logic [31:0] load_addr;
   logic [9:0]  row_left, col_left;
   logic [31:0] pix, ka_full, ia_full, rs_full;

   assign load_addr = 32'(q_cmd.addr);
   assign row_left  = 10'(cfg.ih) - r0_ff;
   assign col_left  = 10'(cfg.iw) - c0_ff;
   assign pix       = 32'(r0_ff) * 32'(cfg.iw) + 32'(c0_ff);
   assign ka_full   = 32'(kf_ff) * 32'(kwch_ff);
   assign ia_full   = 32'(ia_ff) * 32'(cfg.ch);
   assign rs_full   = 32'(cfg.iw) * 32'(cfg.ch);

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && q_cmd.op == OP_LOAD_IMAGE) begin
         img_mem[load_addr[IMG_AW-1:0]] <= q_cmd.sample;
      end
      img_q_ff <= img_mem[ia_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && q_cmd.op == OP_LOAD_KERNEL) begin
         ker_mem[load_addr[KER_AW-1:0]] <= q_cmd.sample;
      end
      ker_q_ff <= ker_mem[ka_ff];
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      r0_in     = r0_ff;
      c0_in     = c0_ff;
      kf_in     = kf_ff;
      kwch_in   = kwch_ff;
      rs_in     = rs_ff;
      ia_in     = ia_ff;
      ia_row_in = ia_row_ff;
      ka_in     = ka_ff;
      ka_row_in = ka_row_ff;
      nrow_in   = nrow_ff;
      ncol_in   = ncol_ff;
      kr_in     = kr_ff;
      kc_in     = kc_ff;
      c_in      = c_ff;
      q_pop     = 1'b0;
      issue     = 1'b0;
      acc_clear = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               if (q_cmd.op == OP_COMPUTE) begin
                  state_in = ST_SETUP1;
               end else if (q_cmd.op == OP_BAD) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SETUP1: begin
            acc_clear = 1'b1;
            r0_in     = 10'(cmd_ff.out_row) * 10'(cfg.sr);
            c0_in     = 10'(cmd_ff.out_col) * 10'(cfg.sc);
            kf_in     = 7'(cmd_ff.filt) * 7'(cfg.kh);
            kwch_in   = 7'(cfg.kw) * 7'(cfg.ch);
            rs_in     = rs_full[IMG_AW-1:0];
            state_in  = ST_SETUP2;
         end
         ST_SETUP2: begin
            ia_in    = pix[IMG_AW-1:0];
            ka_in    = ka_full[KER_AW-1:0];
            nrow_in  = (row_left < 10'(cfg.kh)) ? row_left[3:0] : cfg.kh;
            ncol_in  = (col_left < 10'(cfg.kw)) ? col_left[3:0] : cfg.kw;
            state_in = ST_SETUP3;
         end
         ST_SETUP3: begin
            ia_in     = ia_full[IMG_AW-1:0];
            ia_row_in = ia_full[IMG_AW-1:0];
            ka_row_in = ka_ff;
            kr_in     = '0;
            kc_in     = '0;
            c_in      = '0;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            issue = 1'b1;
            if (c_ff == cfg.ch - 3'd1) begin
               c_in = '0;
               if (kc_ff == ncol_ff - 4'd1) begin
                  kc_in = '0;
                  if (kr_ff == nrow_ff - 4'd1) begin
                     state_in = ST_DRAIN;
                  end else begin
                     kr_in     = kr_ff + 4'd1;
                     ia_row_in = ia_row_ff + rs_ff;
                     ia_in     = ia_row_ff + rs_ff;
                     ka_row_in = ka_row_ff + KER_AW'(kwch_ff);
                     ka_in     = ka_row_ff + KER_AW'(kwch_ff);
                  end
               end else begin
                  kc_in = kc_ff + 4'd1;
                  ia_in = ia_ff + IMG_AW'(1);
                  ka_in = ka_ff + KER_AW'(1);
               end
            end else begin
               c_in  = c_ff + 3'd1;
               ia_in = ia_ff + IMG_AW'(1);
               ka_in = ka_ff + KER_AW'(1);
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !prod_v_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_in.request_bad = (cmd_ff.op == OP_BAD);
      if (cmd_ff.op == OP_BAD) begin
         rsp_in.conv_sum = '0;
      end else if (acc_ff > SUM_MAX) begin
         rsp_in.conv_sum = SUM_MAX[SUM_W-1:0];
      end else if (acc_ff < SUM_MIN) begin
         rsp_in.conv_sum = SUM_MIN[SUM_W-1:0];
      end else begin
         rsp_in.conv_sum = acc_ff[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_v_ff   <= issue;
         prod_v_ff <= rd_v_ff;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      r0_ff     <= r0_in;
      c0_ff     <= c0_in;
      kf_ff     <= kf_in;
      kwch_ff   <= kwch_in;
      rs_ff     <= rs_in;
      ia_ff     <= ia_in;
      ia_row_ff <= ia_row_in;
      ka_ff     <= ka_in;
      ka_row_ff <= ka_row_in;
      nrow_ff   <= nrow_in;
      ncol_ff   <= ncol_in;
      kr_ff     <= kr_in;
      kc_ff     <= kc_in;
      c_ff      <= c_in;
      prod_ff   <= 32'(img_q_ff) * 32'(ker_q_ff);
      if (acc_clear) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== src/strided_multi_filter_convolution.sv =====
// strided 2-d convolution over channels with several stored kernels
//
// req channel: load image word, load kernel word or compute one output.
// loads write the image or kernel store at a flat address, channel fastest.
// a compute item returns one rsp item: the window sum of kernel times image
// starting at (out_row*stride_row, out_col*stride_col), taps past the image
// bottom or right edge skipped; out-of-range coordinates or filter give
// request_bad with a zero sum. loads and unknown types give no rsp item.
// csr port: write enable, register index and data, written while idle.
//
// items pass a 4-entry queue into the datapath. a load is written to its
// store as it leaves the queue. a bad request goes from the queue straight
// to the output register. a compute passes the setup states, then feeds one
// tap and channel per cycle (up to 8*8*4 = 256 at the largest sizes) through
// the single multiply-accumulate and loads the output register once drained.
// reset clears the control state and restores the register defaults; the
// stores hold nothing until loaded. while rsp_stall is high the result stays
// in the output register and the queue keeps accepting until full.
module strided_multi_filter_convolution #(
   parameter int MAX_IMAGE_SIDE  = 64,
   parameter int MAX_CHANNELS    = 4,
   parameter int MAX_KERNEL_SIDE = 8,
   parameter int MAX_FILTERS     = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [smfc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [smfc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  smfc_pkg::smfc_req_type           req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output smfc_pkg::smfc_rsp_type           rsp_payload
);
   import smfc_pkg::*;

   smfc_cfg_type cfg;
   smfc_cmd_type push_cmd, pop_cmd;
   logic         push, full, pop_valid, pop;

   smfc_front #(
      .MAX_IMAGE_SIDE  (MAX_IMAGE_SIDE),
      .MAX_CHANNELS    (MAX_CHANNELS),
      .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE),
      .MAX_FILTERS     (MAX_FILTERS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_payload      (req_payload),
      .q_full           (full),
      .q_push           (push),
      .q_cmd            (push_cmd),
      .cfg              (cfg)
   );

   smfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_cmd   (pop_cmd)
   );

   smfc_back #(
      .MAX_IMAGE_SIDE  (MAX_IMAGE_SIDE),
      .MAX_CHANNELS    (MAX_CHANNELS),
      .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE),
      .MAX_FILTERS     (MAX_FILTERS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_valid     (pop_valid),
      .q_cmd       (pop_cmd),
      .q_pop       (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   assign req_stall = full;

endmodule
